// ===== rtl/core/ppx_pkg.sv =====
// ----------------------------------------------------------------------------
// ppx_pkg
// Shared types, constants and the control store of the packed pixel palette
// expander.
// ----------------------------------------------------------------------------
package ppx_pkg;

    // image geometry
    localparam int MAX_DIM   = 1024;
    localparam int CNT_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = CNT_W + 1;
    localparam int CFG_DIM_W = 11;
    localparam int ORG_W     = 12;
    localparam int COORD_W   = 13;
    localparam int COLOR_W   = 8;
    localparam int PAL_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int TDATA_W   = 40;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BITS_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_HIGH = 3'd6;

    // index size codes
    localparam logic [1:0] MODE_1BPP = 2'd0;
    localparam logic [1:0] MODE_2BPP = 2'd1;

    // sequencer steps
    typedef enum logic [0:0] {
        STEP_FETCH,
        STEP_EMIT
    } step_t;

    // jump conditions
    typedef enum logic [1:0] {
        COND_NEVER,
        COND_IN_XFER,
        COND_PIX_DONE
    } cond_t;

    // one control word
    typedef struct packed {
        logic  take;
        logic  emit;
        cond_t cond;
        step_t target;
    } uword_t;

    // control store: wait for a byte, then emit its pixels one per cycle unless stalled
    function automatic uword_t ucode_rom(step_t step);
        uword_t w;
        w = '{take: 1'b0, emit: 1'b0, cond: COND_NEVER, target: STEP_FETCH};
        case (step)
            STEP_FETCH: w = '{take: 1'b1, emit: 1'b0, cond: COND_IN_XFER,
                              target: STEP_EMIT};
            STEP_EMIT:  w = '{take: 1'b0, emit: 1'b1, cond: COND_PIX_DONE,
                              target: STEP_FETCH};
            default:    w = '{take: 1'b0, emit: 1'b0, cond: COND_NEVER,
                              target: STEP_FETCH};
        endcase
        return w;
    endfunction

    // zero counts as one, oversized saturates
    function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = DIM_W'(v);
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > 32'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

endpackage

// ===== rtl/core/packed_pixel_palette_expander.sv =====
// ----------------------------------------------------------------------------
// packed_pixel_palette_expander
// Expands packed 1/2/4 bit palette indices into colored, placed pixels under
// control of a two-step microprogram.
// ----------------------------------------------------------------------------
// Pixel path: a byte transfer loads the shift register and enters the emit
//   step, which registers the first pixel at the output once it is free.
// Throughput: one pixel per cycle from a shared emit step unless the output
//   stalls; a byte passes one fetch step, then emits 8, 4 or 2 pixels for 1,
//   2 or 4 bit indices, fewer if a row ends inside it; then the next is taken.
// Reset: asynchronous; counters zero, registers to their reset values
//   (width and height one), sequencer waits for a byte, no pixel pending.
module packed_pixel_palette_expander
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration writes
    input  logic                               cfg_we,
    input  logic [ppx_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppx_pkg::PAL_W-1:0]          cfg_data,
    // packed bytes in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] packed_byte
    // pixels out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ppx_pkg::TDATA_W-1:0]        m_tdata,   // [12:0] pixel_x,
                                                          // [25:13] pixel_y,
                                                          // [33:26] pixel_color,
                                                          // [39:34] zero
    output logic                               m_tuser,   // [0] byte_last
    output logic                               m_tlast    // image_last
);

    // configuration registers
    logic [1:0]                        bits_mode_reg;
    logic [ppx_pkg::ORG_W-1:0]         origin_x_reg;
    logic [ppx_pkg::ORG_W-1:0]         origin_y_reg;
    logic [ppx_pkg::CFG_DIM_W-1:0]     width_cfg_reg;
    logic [ppx_pkg::CFG_DIM_W-1:0]     height_cfg_reg;
    logic [ppx_pkg::PAL_W-1:0]         pal_low_reg;
    logic [ppx_pkg::PAL_W-1:0]         pal_high_reg;

    // sequencer and datapath state
    ppx_pkg::step_t                    step_reg, step_next;
    logic [7:0]                        shift_reg, shift_next;
    logic [2:0]                        slot_reg, slot_next;
    logic [ppx_pkg::CNT_W-1:0]         col_reg, col_next;
    logic [ppx_pkg::CNT_W-1:0]         row_reg, row_next;

    // output register
    logic                              out_valid_reg, out_valid_next;
    logic [ppx_pkg::COORD_W-1:0]       out_x_reg, out_x_next;
    logic [ppx_pkg::COORD_W-1:0]       out_y_reg, out_y_next;
    logic [ppx_pkg::COLOR_W-1:0]       out_color_reg, out_color_next;
    logic                              out_blast_reg, out_blast_next;
    logic                              out_ilast_reg, out_ilast_next;

    // datapath signals
    ppx_pkg::uword_t                   uword;
    logic                              in_xfer;
    logic                              out_free;
    logic                              emit_fire;
    logic                              jump;
    logic [ppx_pkg::DIM_W-1:0]         width;
    logic [ppx_pkg::DIM_W-1:0]         height;
    logic [ppx_pkg::DIM_W-1:0]         col_inc;
    logic [ppx_pkg::DIM_W-1:0]         row_inc;
    logic                              row_end;
    logic                              img_end;
    logic                              last_slot;
    logic [2:0]                        slot_max;
    logic [3:0]                        pix_index;
    logic [7:0]                        shift_adv;
    logic [2*ppx_pkg::PAL_W-1:0]       palette;

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_mode_reg  <= ppx_pkg::MODE_1BPP;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            width_cfg_reg  <= ppx_pkg::CFG_DIM_W'(1);
            height_cfg_reg <= ppx_pkg::CFG_DIM_W'(1);
            pal_low_reg    <= '0;
            pal_high_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppx_pkg::REG_BITS_MODE:    bits_mode_reg  <= cfg_data[1:0];
                ppx_pkg::REG_ORIGIN_X:     origin_x_reg   <= cfg_data[ppx_pkg::ORG_W-1:0];
                ppx_pkg::REG_ORIGIN_Y:     origin_y_reg   <= cfg_data[ppx_pkg::ORG_W-1:0];
                ppx_pkg::REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data[ppx_pkg::CFG_DIM_W-1:0];
                ppx_pkg::REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data[ppx_pkg::CFG_DIM_W-1:0];
                ppx_pkg::REG_PALETTE_LOW:  pal_low_reg    <= cfg_data;
                ppx_pkg::REG_PALETTE_HIGH: pal_high_reg   <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // control word fetch and handshake qualifiers
    assign uword     = ppx_pkg::ucode_rom(step_reg);
    assign s_tready  = uword.take;
    assign in_xfer   = s_tvalid && uword.take;
    assign out_free  = !out_valid_reg || m_tready;
    assign emit_fire = uword.emit && out_free;

    // index size decode
    always_comb
    begin
        case (bits_mode_reg)
            ppx_pkg::MODE_1BPP:
            begin
                slot_max  = 3'd7;
                pix_index = {3'b000, shift_reg[7]};
                shift_adv = {shift_reg[6:0], 1'b0};
            end
            ppx_pkg::MODE_2BPP:
            begin
                slot_max  = 3'd3;
                pix_index = {2'b00, shift_reg[7:6]};
                shift_adv = {shift_reg[5:0], 2'b00};
            end
            default:
            begin
                slot_max  = 3'd1;
                pix_index = shift_reg[7:4];
                shift_adv = {shift_reg[3:0], 4'b0000};
            end
        endcase
    end

    // row and image end detection
    assign width     = ppx_pkg::clamp_dim(width_cfg_reg);
    assign height    = ppx_pkg::clamp_dim(height_cfg_reg);
    assign col_inc   = ppx_pkg::DIM_W'(col_reg) + ppx_pkg::DIM_W'(1);
    assign row_inc   = ppx_pkg::DIM_W'(row_reg) + ppx_pkg::DIM_W'(1);
    assign row_end   = col_inc >= width;
    assign img_end   = row_end && (row_inc >= height);
    assign last_slot = slot_reg == slot_max;
    assign palette   = {pal_high_reg, pal_low_reg};

    // conditional jump
    always_comb
    begin
        case (uword.cond)
            ppx_pkg::COND_IN_XFER:  jump = in_xfer;
            ppx_pkg::COND_PIX_DONE: jump = emit_fire && (row_end || last_slot);
            default:                jump = 1'b0;
        endcase
        step_next = jump ? uword.target : step_reg;
    end

    // datapath next state
    always_comb
    begin
        shift_next     = shift_reg;
        slot_next      = slot_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_blast_next = out_blast_reg;
        out_ilast_next = out_ilast_reg;

        // load a new byte
        if (in_xfer)
        begin
            shift_next = s_tdata;
            slot_next  = '0;
        end

        // produce one pixel and advance the counters
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            out_x_next     = ppx_pkg::COORD_W'($signed(origin_x_reg))
                           + ppx_pkg::COORD_W'(col_reg);
            out_y_next     = ppx_pkg::COORD_W'($signed(origin_y_reg))
                           + ppx_pkg::COORD_W'(row_reg);
            out_color_next = palette[{pix_index, 3'b000} +: ppx_pkg::COLOR_W];
            out_blast_next = row_end || last_slot;
            out_ilast_next = img_end;
            shift_next     = shift_adv;
            slot_next      = slot_reg + 3'd1;
            if (row_end)
            begin
                col_next = '0;
                row_next = img_end ? '0 : row_inc[ppx_pkg::CNT_W-1:0];
            end
            else
            begin
                col_next = col_inc[ppx_pkg::CNT_W-1:0];
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ppx_pkg::STEP_FETCH;
            slot_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            slot_reg      <= slot_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        shift_reg     <= shift_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_blast_reg <= out_blast_next;
        out_ilast_reg <= out_ilast_next;
    end

    // output port mapping
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ppx_pkg::TDATA_W - 2*ppx_pkg::COORD_W - ppx_pkg::COLOR_W){1'b0}},
                       out_color_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_blast_reg;
    assign m_tlast  = out_ilast_reg;

    // a byte transfer always starts the emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> step_reg == ppx_pkg::STEP_EMIT)
        else $error("emit step not entered after byte transfer");

    // the image end is also the end of a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ilast_reg |-> out_blast_reg)
        else $error("image end pixel without byte end");

    // the slot counter stays within the byte
    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == ppx_pkg::STEP_EMIT |-> slot_reg <= slot_max)
        else $error("slot counter ran past the byte");

    // counters return to zero after the last pixel of the image
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire && img_end |=> col_reg == '0 && row_reg == '0)
        else $error("counters not cleared at image end");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the packed pixel palette expander. A directed table
// covers the index sizes, palette ends, origin extremes, dimension clamping
// and counters left beyond a shrunk image. Random image phases with random
// registers follow. Every pixel transfer is compared against an in-bench
// expansion model, with random gaps on both streams and one long output hold.
// ----------------------------------------------------------------------------
module testbench;

    // index size codes the package leaves unnamed
    localparam logic [1:0]                    MODE_4BPP  = 2'd2;
    localparam logic [1:0]                    MODE_SPARE = 2'd3;
    // register index with no register behind it
    localparam logic [ppx_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam int PHASES      = 9;
    localparam int PHASE_BYTES = 40;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_LEN    = 300;

    // one pixel as it leaves the block
    typedef struct packed {
        logic [ppx_pkg::COORD_W-1:0] x;
        logic [ppx_pkg::COORD_W-1:0] y;
        logic [ppx_pkg::COLOR_W-1:0] color;
        logic                        blast;
        logic                        ilast;
    } pixel_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_BYTE,
        ROW_TYPED
    } row_kind_t;

    // one directed step: register write, byte, or byte with its pixel typed in
    typedef struct packed {
        row_kind_t                     kind;
        logic [ppx_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [ppx_pkg::PAL_W-1:0]     value;
        logic [7:0]                    pbyte;
        pixel_t                        px;
    } stim_row_t;

    localparam pixel_t NO_PX = '0;

    localparam int DIR_ROWS = 41;
    localparam stim_row_t STIM_TAB [DIR_ROWS] = '{
        // after reset: 1 bit indices, 1x1 image, all colors zero
        '{ROW_TYPED, ppx_pkg::REG_BITS_MODE, 64'h0, 8'hFF,
          '{13'h0000, 13'h0000, 8'h00, 1'b1, 1'b1}},
        '{ROW_CFG,   ppx_pkg::REG_PALETTE_LOW,  64'h0123456789ABCDEF, 8'h00, NO_PX},
        '{ROW_CFG,   ppx_pkg::REG_PALETTE_HIGH, 64'hFEDCBA9876543210, 8'h00, NO_PX},
        '{ROW_TYPED, ppx_pkg::REG_BITS_MODE, 64'h0, 8'h80,
          '{13'h0000, 13'h0000, 8'hCD, 1'b1, 1'b1}},
        '{ROW_TYPED, ppx_pkg::REG_BITS_MODE, 64'h0, 8'h7F,
          '{13'h0000, 13'h0000, 8'hEF, 1'b1, 1'b1}},
        // origin at the far corner
        '{ROW_CFG,   ppx_pkg::REG_ORIGIN_X,     64'h7FF, 8'h00, NO_PX},
        '{ROW_CFG,   ppx_pkg::REG_ORIGIN_Y,     64'h800, 8'h00, NO_PX},
        '{ROW_TYPED, ppx_pkg::REG_BITS_MODE, 64'h0, 8'h00,
          '{13'h07FF, 13'h1800, 8'hEF, 1'b1, 1'b1}},
        // 4 bit indices, top palette entry
        '{ROW_CFG,   ppx_pkg::REG_BITS_MODE,    64'(MODE_4BPP), 8'h00, NO_PX},
        '{ROW_TYPED, ppx_pkg::REG_BITS_MODE, 64'h0, 8'hF0,
          '{13'h07FF, 13'h1800, 8'hFE, 1'b1, 1'b1}},
        // spare mode code acts as 4 bit
        '{ROW_CFG,   ppx_pkg::REG_BITS_MODE,    64'(MODE_SPARE), 8'h00, NO_PX},
        '{ROW_TYPED, ppx_pkg::REG_BITS_MODE, 64'h0, 8'h85,
          '{13'h07FF, 13'h1800, 8'h10, 1'b1, 1'b1}},
        // zero width and height count as one
        '{ROW_CFG,   ppx_pkg::REG_IMAGE_WIDTH,  64'h0, 8'h00, NO_PX},
        '{ROW_TYPED, ppx_pkg::REG_BITS_MODE, 64'h0, 8'h70,
          '{13'h07FF, 13'h1800, 8'h01, 1'b1, 1'b1}},
        '{ROW_CFG,   ppx_pkg::REG_IMAGE_HEIGHT, 64'h0, 8'h00, NO_PX},
        '{ROW_TYPED, ppx_pkg::REG_BITS_MODE, 64'h0, 8'h3C,
          '{13'h07FF, 13'h1800, 8'h89, 1'b1, 1'b1}},
        '{ROW_CFG,   ppx_pkg::REG_ORIGIN_X,     64'h800, 8'h00, NO_PX},
        '{ROW_CFG,   ppx_pkg::REG_ORIGIN_Y,     64'h7FF, 8'h00, NO_PX},
        '{ROW_TYPED, ppx_pkg::REG_BITS_MODE, 64'h0, 8'h1F,
          '{13'h1800, 13'h07FF, 8'hCD, 1'b1, 1'b1}},
        // oversized width saturates, then shrink below the column count
        '{ROW_CFG,   ppx_pkg::REG_BITS_MODE,    64'(ppx_pkg::MODE_1BPP), 8'h00, NO_PX},
        '{ROW_CFG,   ppx_pkg::REG_IMAGE_WIDTH,  64'h7FF, 8'h00, NO_PX},
        '{ROW_CFG,   ppx_pkg::REG_IMAGE_HEIGHT, 64'h3, 8'h00, NO_PX},
        '{ROW_BYTE,  ppx_pkg::REG_BITS_MODE,    64'h0, 8'hA5, NO_PX},
        '{ROW_BYTE,  ppx_pkg::REG_BITS_MODE,    64'h0, 8'h5A, NO_PX},
        '{ROW_CFG,   ppx_pkg::REG_IMAGE_WIDTH,  64'h5, 8'h00, NO_PX},
        '{ROW_BYTE,  ppx_pkg::REG_BITS_MODE,    64'h0, 8'hFF, NO_PX},
        // row count left beyond a shrunk height
        '{ROW_CFG,   ppx_pkg::REG_IMAGE_HEIGHT, 64'h1, 8'h00, NO_PX},
        '{ROW_BYTE,  ppx_pkg::REG_BITS_MODE,    64'h0, 8'h0F, NO_PX},
        // write to the unused index changes nothing
        '{ROW_CFG,   REG_UNUSED,                64'hFFFF_FFFF_FFFF_FFFF, 8'h00, NO_PX},
        '{ROW_BYTE,  ppx_pkg::REG_BITS_MODE,    64'h0, 8'hC3, NO_PX},
        // 2 bit indices with a row ending inside a byte
        '{ROW_CFG,   ppx_pkg::REG_BITS_MODE,    64'(ppx_pkg::MODE_2BPP), 8'h00, NO_PX},
        '{ROW_CFG,   ppx_pkg::REG_IMAGE_WIDTH,  64'h3, 8'h00, NO_PX},
        '{ROW_CFG,   ppx_pkg::REG_IMAGE_HEIGHT, 64'h2, 8'h00, NO_PX},
        '{ROW_BYTE,  ppx_pkg::REG_BITS_MODE,    64'h0, 8'h1B, NO_PX},
        '{ROW_BYTE,  ppx_pkg::REG_BITS_MODE,    64'h0, 8'hE4, NO_PX},
        '{ROW_BYTE,  ppx_pkg::REG_BITS_MODE,    64'h0, 8'h36, NO_PX},
        // largest legal image
        '{ROW_CFG,   ppx_pkg::REG_IMAGE_WIDTH,  64'd1024, 8'h00, NO_PX},
        '{ROW_CFG,   ppx_pkg::REG_IMAGE_HEIGHT, 64'd1024, 8'h00, NO_PX},
        '{ROW_CFG,   ppx_pkg::REG_BITS_MODE,    64'(MODE_4BPP), 8'h00, NO_PX},
        '{ROW_BYTE,  ppx_pkg::REG_BITS_MODE,    64'h0, 8'h69, NO_PX},
        '{ROW_BYTE,  ppx_pkg::REG_BITS_MODE,    64'h0, 8'h96, NO_PX}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [ppx_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ppx_pkg::PAL_W-1:0]     cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;      // [7:0] packed_byte
    logic                          m_tvalid;
    logic                          m_tready;
    logic [ppx_pkg::TDATA_W-1:0]   m_tdata;      // [12:0] pixel_x, [25:13] pixel_y,
                                                 // [33:26] pixel_color, [39:34] zero
    logic                          m_tuser;      // [0] byte_last
    logic                          m_tlast;      // image_last

    // expansion model state, at reset values
    logic [1:0]                    cfg_mode   = ppx_pkg::MODE_1BPP;
    logic [ppx_pkg::ORG_W-1:0]     cfg_ox     = '0;
    logic [ppx_pkg::ORG_W-1:0]     cfg_oy     = '0;
    logic [ppx_pkg::CFG_DIM_W-1:0] cfg_w      = 11'd1;
    logic [ppx_pkg::CFG_DIM_W-1:0] cfg_h      = 11'd1;
    logic [ppx_pkg::PAL_W-1:0]     cfg_pal_lo = '0;
    logic [ppx_pkg::PAL_W-1:0]     cfg_pal_hi = '0;
    int unsigned                   col_cnt    = 0;
    int unsigned                   row_cnt    = 0;

    pixel_t pending_pixels [$];
    pixel_t byte_pixels    [$];
    int     err_cnt     = 0;
    int     px_seen     = 0;
    int     snd_gap_max = 11;
    int     rcv_gap_max = 11;

    packed_pixel_palette_expander uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #3000000;
        $display("[packed_pixel_palette_expander] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // split one byte into pixels, advancing the column and row counters
    function automatic void expand_byte(input logic [7:0] b);
        int unsigned bpp;
        int unsigned per_byte;
        int unsigned wd;
        int unsigned ht;
        int unsigned col;
        int unsigned row;
        logic [3:0]  idx;
        logic        row_end;
        pixel_t      p;
        case (cfg_mode)
            ppx_pkg::MODE_1BPP: bpp = 1;
            ppx_pkg::MODE_2BPP: bpp = 2;
            default:            bpp = 4;
        endcase
        per_byte = 8 / bpp;
        if (cfg_w == '0)
            wd = 1;
        else if (cfg_w > ppx_pkg::MAX_DIM)
            wd = ppx_pkg::MAX_DIM;
        else
            wd = cfg_w;
        if (cfg_h == '0)
            ht = 1;
        else if (cfg_h > ppx_pkg::MAX_DIM)
            ht = ppx_pkg::MAX_DIM;
        else
            ht = cfg_h;
        byte_pixels.delete();
        for (int unsigned k = 0; k < per_byte; k++)
        begin
            idx = 4'((32'(b) >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1));
            col = col_cnt;
            row = row_cnt;
            col_cnt = col + 1;
            row_end = (col_cnt >= wd);
            p.ilast = 1'b0;
            if (row_end)
            begin
                col_cnt = 0;
                row_cnt = row + 1;
                if (row_cnt >= ht)
                begin
                    row_cnt = 0;
                    p.ilast = 1'b1;
                end
            end
            p.x     = {cfg_ox[ppx_pkg::ORG_W-1], cfg_ox} + ppx_pkg::COORD_W'(col);
            p.y     = {cfg_oy[ppx_pkg::ORG_W-1], cfg_oy} + ppx_pkg::COORD_W'(row);
            p.color = idx[3] ? cfg_pal_hi[8*idx[2:0] +: 8] : cfg_pal_lo[8*idx[2:0] +: 8];
            p.blast = row_end || (k + 1 == per_byte);
            byte_pixels.push_back(p);
            if (row_end)
                break;
        end
    endfunction

    // one register write, mirrored into the model at the write edge
    task automatic cfg_write(input logic [ppx_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ppx_pkg::PAL_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            ppx_pkg::REG_BITS_MODE:    cfg_mode   = val[1:0];
            ppx_pkg::REG_ORIGIN_X:     cfg_ox     = val[ppx_pkg::ORG_W-1:0];
            ppx_pkg::REG_ORIGIN_Y:     cfg_oy     = val[ppx_pkg::ORG_W-1:0];
            ppx_pkg::REG_IMAGE_WIDTH:  cfg_w      = val[ppx_pkg::CFG_DIM_W-1:0];
            ppx_pkg::REG_IMAGE_HEIGHT: cfg_h      = val[ppx_pkg::CFG_DIM_W-1:0];
            ppx_pkg::REG_PALETTE_LOW:  cfg_pal_lo = val;
            ppx_pkg::REG_PALETTE_HIGH: cfg_pal_hi = val;
            default:                   ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // offer one byte after a random gap; predict its pixels on transfer
    task automatic send_byte(input logic [7:0] b, input logic typed, input pixel_t typed_px);
        int gap;
        gap = $urandom_range(0, snd_gap_max);
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expand_byte(b);
        if (typed)
            pending_pixels.push_back(typed_px);
        else
            foreach (byte_pixels[i])
                pending_pixels.push_back(byte_pixels[i]);
    endtask

    // let the block go idle before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // dimension: mostly small, sometimes zero, the maximum or oversized
    function automatic logic [ppx_pkg::PAL_W-1:0] pick_dim();
        logic [ppx_pkg::PAL_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0:       r[ppx_pkg::CFG_DIM_W-1:0] = '0;
            1:       r[ppx_pkg::CFG_DIM_W-1:0] = 11'd1024;
            2:       r[ppx_pkg::CFG_DIM_W-1:0] = 11'h7FF;
            3:       r[ppx_pkg::CFG_DIM_W-1:0] = 11'($urandom_range(13, 1023));
            4:       r[ppx_pkg::CFG_DIM_W-1:0] = 11'd1;
            default: r[ppx_pkg::CFG_DIM_W-1:0] = 11'($urandom_range(2, 12));
        endcase
        return r;
    endfunction

    function automatic logic [ppx_pkg::PAL_W-1:0] pick_origin();
        logic [ppx_pkg::PAL_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       r[ppx_pkg::ORG_W-1:0] = 12'h7FF;
            1:       r[ppx_pkg::ORG_W-1:0] = 12'h800;
            2:       r[ppx_pkg::ORG_W-1:0] = '0;
            default: ;
        endcase
        return r;
    endfunction

    // pixel receiver with random stalls and one long hold
    initial
    begin
        int     gap;
        int     hold;
        logic   hold_done;
        pixel_t want;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!hold_done && px_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                for (hold = 0; hold < HOLD_LEN; hold++)
                begin
                    m_tready <= 1'b0;
                    @(posedge clk);
                end
            end
            gap = $urandom_range(0, rcv_gap_max);
            repeat (gap)
            begin
                m_tready <= 1'b0;
                @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            px_seen++;
            if (pending_pixels.size() == 0)
                report_mismatch("pixel with nothing pending", 64'(m_tdata), '0);
            else
            begin
                want = pending_pixels.pop_front();
                if (m_tdata[12:0] !== want.x)
                    report_mismatch("pixel_x", 64'(m_tdata[12:0]), 64'(want.x));
                if (m_tdata[25:13] !== want.y)
                    report_mismatch("pixel_y", 64'(m_tdata[25:13]), 64'(want.y));
                if (m_tdata[33:26] !== want.color)
                    report_mismatch("pixel_color", 64'(m_tdata[33:26]), 64'(want.color));
                if (m_tuser !== want.blast)
                    report_mismatch("byte_last", 64'(m_tuser), 64'(want.blast));
                if (m_tlast !== want.ilast)
                    report_mismatch("image_last", 64'(m_tlast), 64'(want.ilast));
            end
        end
    end

    // reset, directed table, random image phases
    initial
    begin
        stim_row_t                 row;
        logic [ppx_pkg::PAL_W-1:0] val;
        logic [7:0]                b;
        int                        wait_cnt;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = STIM_TAB[r];
            if (row.kind == ROW_CFG)
            begin
                drain();
                cfg_write(row.reg_idx, row.value);
            end
            else
                send_byte(row.pbyte, row.kind == ROW_TYPED, row.px);
        end

        // random phases: new registers, then a run of bytes
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            snd_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
            rcv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
            for (int i = 0; i < 7; i++)
            begin
                if (ph == 0 || $urandom_range(0, 1) == 1)
                begin
                    case (ppx_pkg::CFG_IDX_W'(i))
                        ppx_pkg::REG_ORIGIN_X, ppx_pkg::REG_ORIGIN_Y:
                            val = pick_origin();
                        ppx_pkg::REG_IMAGE_WIDTH, ppx_pkg::REG_IMAGE_HEIGHT:
                            val = pick_dim();
                        default:
                            val = {$urandom, $urandom};
                    endcase
                    cfg_write(ppx_pkg::CFG_IDX_W'(i), val);
                end
            end
            if ($urandom_range(0, 3) == 0)
                cfg_write(REG_UNUSED, {$urandom, $urandom});
            for (int n = 0; n < PHASE_BYTES; n++)
            begin
                case ($urandom_range(0, 15))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_byte(b, 1'b0, NO_PX);
            end
        end

        // wait out the last pixels
        s_tvalid <= 1'b0;
        wait_cnt = 0;
        while (pending_pixels.size() != 0 && wait_cnt < 20000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (16) @(posedge clk);
        if (pending_pixels.size() != 0)
            report_mismatch("pixels never delivered", 64'(pending_pixels.size()), '0);
        if (err_cnt == 0)
            $display("[packed_pixel_palette_expander] OK");
        else
            $display("[packed_pixel_palette_expander] ERROR");
        $finish;
    end

endmodule
